// ===== src/base64_decoder_assert.svh =====
// Assertion macros for the base64 decoder RTL.
// Included by b64d_queue, which checks its own logic; no other dependencies.
`ifndef BASE64_DECODER_ASSERT_SVH
`define BASE64_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define B64D_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked out of reset.
`define B64D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define B64D_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define B64D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/b64d_pkg.sv =====
// Shared types, constants and the character decode function of the base64 decoder.
// No dependencies.
package b64d_pkg;

	localparam int B64D_QUEUE_DEPTH = 2;
	localparam int GROUP_W = 24;
	localparam int SEXTET_W = 6;

	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       group_last;
	} out_item_t;

	// One decoded group moving between the front, the queue and the back
	typedef struct packed {
		logic               valid;
		logic [GROUP_W-1:0] group;
	} grp_beat_t;

	typedef struct packed {
		logic                valid;
		logic [SEXTET_W-1:0] value;
	} sextet_t;

	localparam logic [SEXTET_W-1:0] SX_DIGIT_BASE = 6'd52;
	localparam logic [SEXTET_W-1:0] SX_LOWER_BASE = 6'd26;
	localparam logic [SEXTET_W-1:0] SX_PLUS       = 6'd62;
	localparam logic [SEXTET_W-1:0] SX_SLASH      = 6'd63;
	localparam logic [SEXTET_W-1:0] SX_PAD        = 6'd0;

	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t    s;
		logic [7:0] d;
		s.valid = 1'b1;
		s.value = SX_PAD;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
			s.value = d[SEXTET_W-1:0] + SX_DIGIT_BASE;
		end else if (c >= 8'h41 && c <= 8'h5a) begin
			d = c - 8'h41;
			s.value = d[SEXTET_W-1:0];
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			d = c - 8'h61;
			s.value = d[SEXTET_W-1:0] + SX_LOWER_BASE;
		end else if (c == 8'h2b) begin
			s.value = SX_PLUS;
		end else if (c == 8'h2f) begin
			s.value = SX_SLASH;
		end else if (c == 8'h3d) begin
			s.value = SX_PAD;
		end else begin
			s.valid = 1'b0;
		end
		return s;
	endfunction

endpackage

// ===== src/b64d_queue.sv =====
// Short queue of decoded groups between the decode front and the byte back end.
// Depends on b64d_pkg and base64_decoder_assert.svh.
`include "base64_decoder_assert.svh"

module b64d_queue import b64d_pkg::*; #(
	parameter int DEPTH = B64D_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  grp_beat_t wr,
	output logic      full,
	output grp_beat_t head,
	input  logic      rd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [GROUP_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign full       = (count_q == CNT_FULL);
	assign head.valid = (count_q != '0);
	assign head.group = slot_q[rd_ptr_q];
	assign do_wr      = wr.valid && !full;
	assign do_rd      = rd && head.valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr.group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`B64D_ASSERT_NOW(a_no_wr_when_full, clk, arst_n, wr.valid, !full, "group beat dropped: queue full")
	`B64D_ASSERT_NOW(a_no_rd_when_empty, clk, arst_n, rd, head.valid, "group read from empty queue")
	`B64D_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_FULL, "queue count beyond depth")
	`B64D_ASSERT_NEXT(a_count_up, clk, arst_n, do_wr && !do_rd, count_q == $past(count_q) + 1'b1, "queue count did not advance on write")

endmodule

// ===== src/b64d_front.sv =====
// Decode front: accepts characters, maps them to sextets and packs groups of four.
// Depends on b64d_pkg.
module b64d_front import b64d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	input  logic      q_full,
	output grp_beat_t grp
);

	logic [GROUP_W-1:0] acc_q;
	logic [1:0]         count_q;
	logic               take;
	sextet_t            sx;
	logic [GROUP_W-1:0] acc_shift;

	assign full      = q_full;
	assign take      = push && !full;
	assign sx        = sextet_of(item.in_char);
	assign acc_shift = {acc_q[GROUP_W-SEXTET_W-1:0], sx.value};

	// Hand a group to the queue on the fourth valid character
	assign grp.valid = take && sx.valid && (count_q == 2'd3);
	assign grp.group = acc_shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			count_q <= '0;
		end else if (take) begin
			if (item.end_of_string) begin
				acc_q   <= '0;
				count_q <= '0;
			end else if (sx.valid) begin
				acc_q   <= acc_shift;
				count_q <= count_q + 2'd1;
			end
		end
	end

endmodule

// ===== src/b64d_back.sv =====
// Byte back end: takes groups from the queue and presents their three bytes in turn.
// Depends on b64d_pkg.
module b64d_back import b64d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  grp_beat_t head,
	output logic      q_rd,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	localparam logic [1:0] BYTE_HI  = 2'd0;
	localparam logic [1:0] BYTE_MID = 2'd1;
	localparam logic [1:0] BYTE_LO  = 2'd2;

	logic [GROUP_W-1:0] grp_q;
	logic [1:0]         idx_q;
	logic               have_q;
	logic               done;

	assign empty = !have_q;
	assign done  = have_q && pop && (idx_q == BYTE_LO);
	assign q_rd  = head.valid && (!have_q || done);

	always_comb begin
		unique case (idx_q)
			BYTE_HI:  result.out_byte = grp_q[23:16];
			BYTE_MID: result.out_byte = grp_q[15:8];
			default:  result.out_byte = grp_q[7:0];
		endcase
		result.group_last = (idx_q == BYTE_LO);
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			grp_q <= head.group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= BYTE_HI;
			have_q <= 1'b0;
		end else if (q_rd) begin
			// Load the next group right behind the last byte of this one
			idx_q  <= BYTE_HI;
			have_q <= 1'b1;
		end else if (done) begin
			have_q <= 1'b0;
		end else if (have_q && pop) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

// ===== src/base64_decoder.sv =====
// Streaming base64 decoder: one char in per cycle unless full, three byte beats per group out.
// A finished group is queued, then registered in the back end, where its first byte is shown.
// Throughput: one character per cycle unless full; one byte per pop cycle, set by the back end.
// full rises only while the group queue holds QUEUE_DEPTH groups.
// Reset (arst_n low) clears the accumulator, group count, queue and output state.
module base64_decoder import b64d_pkg::*; #(
	parameter int QUEUE_DEPTH = B64D_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	grp_beat_t wr_grp;
	grp_beat_t head_grp;
	logic      q_full;
	logic      q_rd;

	b64d_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_full (q_full),
		.grp    (wr_grp)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr_grp),
		.full   (q_full),
		.head   (head_grp),
		.rd     (q_rd)
	);

	b64d_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head_grp),
		.q_rd   (q_rd),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule
